// ===== design/pdt_pkg.sv =====
// Shared types and constants for the timestamped deadband PID block.
// Used by the channel interfaces, the controller and the datapath.
// No dependencies.
`default_nettype none

package pdt_pkg;

  // Timestamp format is fixed: unsigned seconds, Q32.16.
  localparam int TIME_WIDTH = 48;

  // Multiplier digit width: bits of the second operand consumed per step.
  localparam int MUL_DIGIT = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 2'd2;

  // Operand pairs for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_INTEG,   // error x interval
    MUL_PROP,    // proportional gain x error
    MUL_INTG,    // integral gain x integral sum
    MUL_DERIV    // derivative gain x derivative
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     calc_err;
    logic     band;
    logic     div_start;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     acc_clear;
    logic     acc_add;
    logic     integ_upd;
    logic     finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_dt;
    logic mul_done;
    logic div_busy;
  } status_t;

endpackage

`default_nettype wire

// ===== design/pdt_ifs.sv =====
// Valid/ready channel interfaces: sample input, result output, config write.
// Depends on pdt_pkg for the timestamp width and register index width.
`default_nettype none

interface pdt_sample_if #(parameter int VALUE_WIDTH = 32);
  logic                                valid;
  logic                                ready;
  logic signed [VALUE_WIDTH-1:0]       measured;
  logic signed [VALUE_WIDTH-1:0]       setpoint;
  logic        [VALUE_WIDTH-2:0]       deadband;
  logic        [pdt_pkg::TIME_WIDTH-1:0] timestamp;

  modport source (output valid, measured, setpoint, deadband, timestamp, input ready);
  modport sink   (input valid, measured, setpoint, deadband, timestamp, output ready);
endinterface

interface pdt_result_if #(parameter int VALUE_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] drive;
  logic                          clipped;
  logic                          zero_interval;

  modport source (output valid, drive, clipped, zero_interval, input ready);
  modport sink   (input valid, drive, clipped, zero_interval, output ready);
endinterface

interface pdt_cfg_if #(parameter int VALUE_WIDTH = 32);
  logic                            valid;
  logic                            ready;
  logic [pdt_pkg::CFG_IDX_W-1:0]   index;
  logic [VALUE_WIDTH-1:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/pdt_mul.sv =====
// Sign-magnitude multiplier, one MUL_DIGIT-wide digit of op_b per cycle.
// Depends on pdt_pkg for the digit width.
`default_nettype none

module pdt_mul #(
  parameter int OP_WIDTH = 49
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [OP_WIDTH-1:0]   op_a,
  input  logic signed [OP_WIDTH-1:0]   op_b,
  output logic                         busy,
  output logic                         done,
  output logic                         neg,
  output logic        [2*OP_WIDTH-1:0] prod
);

  localparam int DIG   = pdt_pkg::MUL_DIGIT;
  localparam int STEPS = (OP_WIDTH + DIG - 1) / DIG;
  localparam int NB    = STEPS * DIG;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int FW    = OP_WIDTH + NB;

  logic [OP_WIDTH-1:0]     ua;
  logic [OP_WIDTH-1:0]     hi;
  logic [NB-1:0]           lo;
  logic [CW-1:0]           cnt;
  logic [OP_WIDTH-1:0]     mag_a;
  logic [OP_WIDTH-1:0]     mag_b;
  logic [OP_WIDTH+DIG-1:0] sum;
  logic [FW-1:0]           full;

  assign mag_a = op_a[OP_WIDTH-1] ? $unsigned(-op_a) : $unsigned(op_a);
  assign mag_b = op_b[OP_WIDTH-1] ? $unsigned(-op_b) : $unsigned(op_b);

  // Partial product of one digit, added into the upper half.
  assign sum  = {{DIG{1'b0}}, hi} + (ua * lo[DIG-1:0]);
  assign full = {hi, lo};
  assign prod = full[2*OP_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      ua  <= mag_a;
      hi  <= '0;
      lo  <= NB'(mag_b);
      neg <= op_a[OP_WIDTH-1] ^ op_b[OP_WIDTH-1];
    end else if (busy) begin
      hi <= sum[OP_WIDTH+DIG-1:DIG];
      lo <= {sum[DIG-1:0], lo[NB-1:DIG]};
    end
  end

endmodule

`default_nettype wire

// ===== design/pdt_div.sv =====
// Restoring divider for the derivative: (num * 2^FRAC_BITS) / den,
// truncated toward zero and saturated. One quotient bit per cycle. Uses pdt_pkg.
`default_nettype none

module pdt_div #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [VALUE_WIDTH:0]         num,
  input  logic signed [pdt_pkg::TIME_WIDTH:0] den,
  output logic                                busy,
  output logic signed [VALUE_WIDTH-1:0]       quot
);

  localparam int TW = pdt_pkg::TIME_WIDTH;
  localparam int VW = VALUE_WIDTH;
  localparam int DW = VW + 1 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic          run;
  logic          fin;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dvd;
  logic [TW-1:0] rem;
  logic [TW-1:0] ud;
  logic [VW-1:0] q;
  logic          over;
  logic          neg;

  logic [VW:0]   mag_n;
  logic [TW:0]   mag_d;
  logic [TW:0]   r2;
  logic [TW:0]   r_sub;
  logic          ge;
  logic [VW-1:0] lim;
  logic [VW-1:0] qs;

  assign mag_n = num[VW] ? $unsigned(-num) : $unsigned(num);
  assign mag_d = den[TW] ? $unsigned(-den) : $unsigned(den);

  assign r2    = {rem, dvd[DW-1]};
  assign ge    = r2 >= {1'b0, ud};
  assign r_sub = r2 - {1'b0, ud};

  // Negative results may reach the most negative value.
  assign lim = neg ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
  assign qs  = (over || (q > lim)) ? lim : q;

  assign busy = run | fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      cnt <= '0;
    end else begin
      fin <= 1'b0;
      if (start && !busy) begin
        run <= 1'b1;
        cnt <= CW'(DW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dvd  <= {mag_n, {FRAC_BITS{1'b0}}};
      rem  <= '0;
      ud   <= mag_d[TW-1:0];
      q    <= '0;
      over <= 1'b0;
      neg  <= num[VW] ^ den[TW];
    end else if (run) begin
      rem  <= ge ? r_sub[TW-1:0] : r2[TW-1:0];
      dvd  <= dvd << 1;
      q    <= {q[VW-2:0], ge};
      // A set top bit shifted out means the quotient is past any limit.
      over <= over | q[VW-1];
    end else if (fin) begin
      quot <= neg ? (~qs + 1'b1) : qs;
    end
  end

endmodule

`default_nettype wire

// ===== design/pdt_dpath.sv =====
// Datapath: input and gain registers, error and deadband logic, integral and
// accumulator, result registers. Holds pdt_mul and pdt_div. Uses pdt_pkg.
`default_nettype none

module pdt_dpath #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pdt_pkg::cmd_t                        cmd,
  output pdt_pkg::status_t                     status,
  input  logic signed [VALUE_WIDTH-1:0]        measured,
  input  logic signed [VALUE_WIDTH-1:0]        setpoint,
  input  logic        [VALUE_WIDTH-2:0]        deadband,
  input  logic        [pdt_pkg::TIME_WIDTH-1:0] timestamp,
  input  logic                                 cfg_we,
  input  logic        [pdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [VALUE_WIDTH-1:0]        cfg_data,
  output logic signed [VALUE_WIDTH-1:0]        drive,
  output logic                                 clipped,
  output logic                                 zero_interval
);

  localparam int VW = VALUE_WIDTH;
  localparam int TW = pdt_pkg::TIME_WIDTH;
  localparam int IW = TW + 1;
  localparam int MW = (VW > IW) ? VW : IW;
  localparam int AW = 2 * MW + 3;

  localparam logic [VW-1:0] MAXV = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] MINV = {1'b1, {(VW-1){1'b0}}};

  // Gains
  logic signed [VW-1:0] gain_p;
  logic signed [VW-1:0] gain_i;
  logic signed [VW-1:0] gain_d;

  // Captured request
  logic signed [VW-1:0] meas_q;
  logic signed [VW-1:0] setp_q;
  logic        [VW-2:0] band_q;
  logic        [TW-1:0] now_q;

  // Working registers
  logic signed [VW-1:0] err;
  logic signed [VW:0]   dnum;
  logic signed [IW-1:0] interval;
  logic                 zdt;
  logic signed [AW-1:0] acc;
  logic                 clip_q;

  // Loop state
  logic signed [VW-1:0] integral;
  logic signed [VW-1:0] last_error;
  logic        [TW-1:0] last_time;

  // Combinational
  logic signed [VW:0]   diff;
  logic        [VW-1:0] err_sat;
  logic signed [IW-1:0] interval_calc;
  logic        [VW-1:0] mag;
  logic                 keep;
  logic signed [VW:0]   d_keep;
  logic signed [VW:0]   d_zero;
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic                 mul_busy;
  logic                 mul_done;
  logic                 mul_neg;
  logic [2*MW-1:0]      mul_prod;
  logic signed [AW-1:0] p_ext;
  logic signed [VW-1:0] div_quot;
  logic                 div_busy;
  logic signed [VW-1:0] deriv;
  logic signed [AW-1:0] acc_sh;
  logic signed [AW-1:0] integ_sum;
  logic                 integ_fit;
  logic        [VW-1:0] integ_sat;
  logic                 drive_fit;
  logic        [VW-1:0] drive_sat;

  // Error, saturated to a value
  assign diff    = (VW+1)'(setp_q) - (VW+1)'(meas_q);
  assign err_sat = (diff[VW] != diff[VW-1]) ? (diff[VW] ? MINV : MAXV) : diff[VW-1:0];

  assign interval_calc = $signed({1'b0, now_q}) - $signed({1'b0, last_time});

  // Deadband: keep the error when its magnitude reaches the band
  assign mag    = err[VW-1] ? $unsigned(-err) : $unsigned(err);
  assign keep   = mag >= {1'b0, band_q};
  assign d_keep = (VW+1)'(err) - (VW+1)'(last_error);
  assign d_zero = -((VW+1)'(last_error));

  assign deriv = zdt ? '0 : div_quot;

  always_comb begin
    case (cmd.mul_sel)
      pdt_pkg::MUL_INTEG: begin
        mul_a = MW'(err);
        mul_b = MW'(interval);
      end
      pdt_pkg::MUL_PROP: begin
        mul_a = MW'(gain_p);
        mul_b = MW'(err);
      end
      pdt_pkg::MUL_INTG: begin
        mul_a = MW'(gain_i);
        mul_b = MW'(integral);
      end
      pdt_pkg::MUL_DERIV: begin
        mul_a = MW'(gain_d);
        mul_b = MW'(deriv);
      end
      default: begin
        mul_a = MW'(err);
        mul_b = MW'(interval);
      end
    endcase
  end

  pdt_mul #(
    .OP_WIDTH (MW)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .neg   (mul_neg),
    .prod  (mul_prod)
  );

  pdt_div #(
    .VALUE_WIDTH (VW),
    .FRAC_BITS   (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (dnum),
    .den   (interval),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  assign p_ext = $signed(AW'(mul_prod));

  // Floor division by 2^FRAC_BITS, then saturation
  assign acc_sh    = acc >>> FRAC_BITS;
  assign integ_sum = acc_sh + AW'(integral);
  assign integ_fit = (integ_sum[AW-1:VW-1] == {(AW-VW+1){integ_sum[VW-1]}});
  assign integ_sat = integ_fit ? integ_sum[VW-1:0] : (integ_sum[AW-1] ? MINV : MAXV);
  assign drive_fit = (acc_sh[AW-1:VW-1] == {(AW-VW+1){acc_sh[VW-1]}});
  assign drive_sat = drive_fit ? acc_sh[VW-1:0] : (acc_sh[AW-1] ? MINV : MAXV);

  assign status.zero_dt  = zdt;
  assign status.mul_done = mul_done;
  assign status.div_busy = div_busy | mul_busy & 1'b0;

  // Gains and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p     <= '0;
      gain_i     <= '0;
      gain_d     <= '0;
      integral   <= '0;
      last_error <= '0;
      last_time  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pdt_pkg::REG_GAIN_PROP:  gain_p <= cfg_data;
          pdt_pkg::REG_GAIN_INTEG: gain_i <= cfg_data;
          pdt_pkg::REG_GAIN_DERIV: gain_d <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.integ_upd) begin
        integral <= integ_sat;
      end
      if (cmd.finish) begin
        last_error <= err;
        last_time  <= now_q;
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      meas_q <= measured;
      setp_q <= setpoint;
      band_q <= deadband;
      now_q  <= timestamp;
    end
    if (cmd.calc_err) begin
      err      <= err_sat;
      interval <= interval_calc;
      zdt      <= (now_q == last_time);
    end
    if (cmd.band) begin
      err  <= keep ? err : '0;
      dnum <= keep ? d_keep : d_zero;
    end
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= mul_neg ? (acc - p_ext) : (acc + p_ext);
    end
    if (cmd.integ_upd) begin
      clip_q <= !integ_fit;
    end
    if (cmd.finish) begin
      drive         <= drive_sat;
      clipped       <= clip_q | !drive_fit;
      zero_interval <= zdt;
    end
  end

endmodule

`default_nettype wire

// ===== design/pdt_ctrl.sv =====
// Sequencer for one sample: error, deadband, integral, gain products, result.
// Drives pdt_dpath through pdt_pkg::cmd_t and reads pdt_pkg::status_t.
`default_nettype none

module pdt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  output logic             result_valid,
  input  logic             result_ready,
  input  pdt_pkg::status_t status,
  output pdt_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_BAND,
    S_START,
    S_MUL_INT,
    S_INTEG,
    S_MUL_P,
    S_MUL_I,
    S_WAIT_D,
    S_MUL_D,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign sample_ready = (state == S_IDLE);
  assign out_free     = !result_valid || result_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        cmd.calc_err = 1'b1;
        state_next   = S_BAND;
      end
      S_BAND: begin
        cmd.band   = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        // Skip the divider when the interval is zero
        cmd.div_start = !status.zero_dt;
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = pdt_pkg::MUL_INTEG;
        cmd.acc_clear = 1'b1;
        state_next    = S_MUL_INT;
      end
      S_MUL_INT: begin
        if (status.mul_done) begin
          cmd.acc_add = 1'b1;
          state_next  = S_INTEG;
        end
      end
      S_INTEG: begin
        cmd.integ_upd = 1'b1;
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = pdt_pkg::MUL_PROP;
        cmd.acc_clear = 1'b1;
        state_next    = S_MUL_P;
      end
      S_MUL_P: begin
        if (status.mul_done) begin
          cmd.acc_add   = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = pdt_pkg::MUL_INTG;
          state_next    = S_MUL_I;
        end
      end
      S_MUL_I: begin
        if (status.mul_done) begin
          cmd.acc_add = 1'b1;
          state_next  = S_WAIT_D;
        end
      end
      S_WAIT_D: begin
        if (!status.div_busy) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = pdt_pkg::MUL_DERIV;
          state_next    = S_MUL_D;
        end
      end
      S_MUL_D: begin
        if (status.mul_done) begin
          cmd.acc_add = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/pid_deadband_timestamped.sv =====
// PID controller with deadband on timestamped samples. Each sample request
// carries measured, setpoint, deadband and timestamp (fixed point with FRAC_BITS
// fraction bits, signed but for the deadband; timestamp unsigned Q32.16). The
// block forms the interval since the previous sample, the error setpoint minus
// measured (saturated, and forced to zero when its magnitude is below the
// deadband), a saturating integral of error times interval, and a derivative of
// the error change over the interval, then returns the saturated gain-weighted
// sum as drive. clipped reports saturation of the integral or of drive;
// zero_interval reports a zero interval, for which the derivative is zero.
// Gains are written through the cfg channel (index 0 proportional, 1 integral,
// 2 derivative; other indexes are ignored) and cfg is always ready. Throughput:
// one sample at a time. With a nonzero interval the sample time is set by the
// bit-serial divider that produces the derivative, one quotient bit per cycle;
// the multiplier products overlap it. With a zero interval the divider is
// skipped and the sample time is set by four passes through the shared
// 16-bit-digit multiplier. The finished result sits in an output register, so
// the next sample is taken while it waits; only the final step stalls on a
// full output register.
// Depends on pdt_pkg, pdt_ifs, pdt_ctrl, pdt_dpath.
`default_nettype none

module pid_deadband_timestamped #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst,
  pdt_sample_if.sink   sample,
  pdt_result_if.source result,
  pdt_cfg_if.sink      cfg
);

  pdt_pkg::cmd_t    cmd;
  pdt_pkg::status_t status;

  // Gain writes are never held off; each is registered at its handshake
  assign cfg.ready = 1'b1;

  // Sequencer: accepts one request, steps the datapath, posts the result
  pdt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Arithmetic, loop state and result registers
  pdt_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .measured      (sample.measured),
    .setpoint      (sample.setpoint),
    .deadband      (sample.deadband),
    .timestamp     (sample.timestamp),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .drive         (result.drive),
    .clipped       (result.clipped),
    .zero_interval (result.zero_interval)
  );

endmodule

`default_nettype wire

// ===== dv/pid_deadband_timestamped_test.sv =====
// Self-checking testbench for pid_deadband_timestamped: a directed table, then random
// phases of gains and samples, scored against typed rows or a bit-exact predictor.
// Depends on pdt_pkg, the pdt_*_if interfaces and the block itself.
module pid_deadband_timestamped_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pdt_pkg::*;

  localparam int VW = 32;
  localparam int FB = 16;

  // The block decodes two index bits; index 3 names no register and must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
  localparam int RESULT_HOLD   = 400;   // long receiver hold-off, fills the block
  localparam int SETTLE_CYCLES = 150;   // quiet time after the last result before the verdict
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 100;

  localparam logic signed [127:0] VAL_MAX = (128'sd1 <<< (VW - 1)) - 128'sd1;
  localparam logic signed [127:0] VAL_MIN = -(128'sd1 <<< (VW - 1));

  typedef struct packed {
    logic signed [VW-1:0]   measured;
    logic signed [VW-1:0]   setpoint;
    logic [VW-2:0]          deadband;
    logic [TIME_WIDTH-1:0]  timestamp;
  } sample_t;

  typedef struct packed {
    logic signed [VW-1:0] drive;
    logic                 clipped;
    logic                 zero_interval;
  } outcome_t;

  typedef enum logic {ROW_SAMPLE, ROW_GAINS} row_kind_t;

  typedef struct {
    row_kind_t kind;
    sample_t   stim;
    bit        typed;
    outcome_t  want;
    logic [VW-1:0] gp;
    logic [VW-1:0] gi;
    logic [VW-1:0] gd;
    bit        poke;
  } row_t;

  logic clk;
  logic rst;

  pdt_sample_if #(.VALUE_WIDTH(VW)) smp_ch ();
  pdt_result_if #(.VALUE_WIDTH(VW)) res_ch ();
  pdt_cfg_if    #(.VALUE_WIDTH(VW)) cfg_ch ();

  pid_deadband_timestamped #(.VALUE_WIDTH(VW), .FRAC_BITS(FB)) dut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // Predictor copy of the gains and of the controller state.
  logic signed [VW-1:0]  gain_p = '0;
  logic signed [VW-1:0]  gain_i = '0;
  logic signed [VW-1:0]  gain_d = '0;
  logic signed [VW-1:0]  err_prev = '0;
  logic signed [VW-1:0]  integ_sum = '0;
  logic [TIME_WIDTH-1:0] time_prev = '0;

  outcome_t drive_expected[$];    // results owed by the block, oldest first
  row_t     directed[$];
  logic [TIME_WIDTH-1:0] gen_time = '0;  // timestamp of the last generated sample
  bit       back_to_back = 1'b0;         // sender offers with no gaps when set
  int       hold_requests = 0;           // bumped by the sequencer
  int       holds_done = 0;              // bumped by the result sink
  int       mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturate a wide signed value to the value range; hit tells whether it clamped.
  function automatic logic signed [VW-1:0] clamp_value(input logic signed [127:0] v,
                                                       output logic hit);
    hit = 1'b1;
    if (v > VAL_MAX) return VAL_MAX[VW-1:0];
    if (v < VAL_MIN) return VAL_MIN[VW-1:0];
    hit = 1'b0;
    return v[VW-1:0];
  endfunction

  // Advance the controller by one sample and return the result it owes.
  function automatic outcome_t predict_step(input sample_t s);
    logic signed [63:0]  interval, diff, e64, p64, num;
    logic signed [VW-1:0] err;
    logic [63:0]         mag, un, ud;
    logic [127:0]        quot, lim;
    logic signed [127:0] e_w, iv_w, i_w, d_w, acc;
    logic                neg, hit_int, hit_out, unused;
    outcome_t            o;
    interval = $signed({16'd0, s.timestamp}) - $signed({16'd0, time_prev});
    diff = $signed(s.setpoint) - $signed(s.measured);
    // Error saturation is silent: it never sets clipped.
    err = clamp_value(diff, unused);
    e64 = err;
    mag = (e64 < 0) ? -e64 : e64;
    // Strictly below the band drops the error; equal to the band keeps it.
    if (mag < {33'd0, s.deadband}) err = '0;
    e_w  = err;
    iv_w = interval;
    i_w  = integ_sum;
    acc  = i_w + ((e_w * iv_w) >>> FB);
    integ_sum = clamp_value(acc, hit_int);

    o.zero_interval = (interval == 0);
    if (interval == 0) begin
      d_w = '0;
    end else begin
      // Quotient of the error change over the interval, truncated toward zero.
      e64 = err;
      p64 = err_prev;
      num = e64 - p64;
      neg = (num < 0) != (interval < 0);
      un  = (num < 0) ? -num : num;
      ud  = (interval < 0) ? -interval : interval;
      quot = ({64'd0, un} << FB) / {64'd0, ud};
      lim  = neg ? (128'd1 << (VW - 1)) : (128'd1 << (VW - 1)) - 128'd1;
      if (quot > lim) quot = lim;
      d_w = neg ? -$signed(quot) : $signed(quot);
    end

    i_w = integ_sum;
    acc = ($signed(128'(gain_p)) * e_w + $signed(128'(gain_i)) * i_w
           + $signed(128'(gain_d)) * d_w) >>> FB;
    o.drive   = clamp_value(acc, hit_out);
    o.clipped = hit_int | hit_out;

    err_prev  = err;
    time_prev = s.timestamp;
    return o;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 120);
  endfunction

  function automatic logic [VW-1:0] pick_gain();
    logic [VW-1:0] r;
    r = $urandom_range(0, 32'h0004_0000);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h0001_0000;
      4: return $urandom_range(0, 1) ? (32'd0 - r) : r;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a well-behaved control loop: time creeps forward, measured tracks the
  // setpoint, the band is small. The rest is zero and backward intervals, full
  // random fields and the extremes.
  function automatic sample_t make_sample();
    sample_t s;
    int r, base;
    logic signed [63:0] diff;
    logic [63:0] mag;
    r = $urandom_range(0, 99);
    if (r < 70)      s.timestamp = gen_time + $urandom_range(1, 32'h0004_0000);
    else if (r < 80) s.timestamp = gen_time;
    else if (r < 88) s.timestamp = gen_time - $urandom_range(1, 32'h0002_0000);
    else if (r < 95) s.timestamp = {16'($urandom), 32'($urandom)};
    else             s.timestamp = $urandom_range(0, 1) ? '1 : '0;
    gen_time = s.timestamp;

    r = $urandom_range(0, 99);
    if (r < 60) begin
      base = int'($urandom_range(0, 200 << 16)) - (100 << 16);
      s.setpoint = base;
      s.measured = base + int'($urandom_range(0, 8 << 16)) - (4 << 16);
    end else if (r < 85) begin
      s.setpoint = $urandom;
      s.measured = $urandom;
    end else begin
      s.setpoint = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      s.measured = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    end

    diff = $signed(s.setpoint) - $signed(s.measured);
    mag  = (diff < 0) ? -diff : diff;
    if (mag > 64'h7fff_ffff) mag = 64'h7fff_ffff;
    r = $urandom_range(0, 99);
    if (r < 50)      s.deadband = 31'($urandom_range(0, 2 << 16));
    else if (r < 65) s.deadband = '0;
    else if (r < 80) s.deadband = 31'($urandom);
    else if (r < 92) s.deadband = mag[VW-2:0];
    else             s.deadband = '1;
    return s;
  endfunction

  function automatic row_t sample_row(input logic [VW-1:0] m, input logic [VW-1:0] sp,
                                      input logic [VW-2:0] b, input logic [TIME_WIDTH-1:0] t);
    row_t w;
    w = '{kind: ROW_SAMPLE, stim: '{m, sp, b, t}, typed: 1'b0, want: '0,
          gp: '0, gi: '0, gd: '0, poke: 1'b0};
    return w;
  endfunction

  function automatic row_t checked_row(input logic [VW-1:0] m, input logic [VW-1:0] sp,
                                       input logic [VW-2:0] b, input logic [TIME_WIDTH-1:0] t,
                                       input logic [VW-1:0] d, input logic c, input logic z);
    row_t w;
    w = sample_row(m, sp, b, t);
    w.typed = 1'b1;
    w.want  = '{d, c, z};
    return w;
  endfunction

  function automatic row_t gains_row(input logic [VW-1:0] gp, input logic [VW-1:0] gi,
                                     input logic [VW-1:0] gd, input bit poke);
    row_t w;
    w = '{kind: ROW_GAINS, stim: '0, typed: 1'b0, want: '0,
          gp: gp, gi: gi, gd: gd, poke: poke};
    return w;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // Offer one sample request, hold it until taken, then book its expected result.
  // A typed expectation replaces the predicted one; the predictor still advances.
  task automatic offer_sample(input sample_t s, input bit typed, input outcome_t want);
    outcome_t predicted;
    int gap;
    smp_ch.valid     <= 1'b1;
    smp_ch.measured  <= s.measured;
    smp_ch.setpoint  <= s.setpoint;
    smp_ch.deadband  <= s.deadband;
    smp_ch.timestamp <= s.timestamp;
    do @(posedge clk); while (!smp_ch.ready);
    predicted = predict_step(s);
    drive_expected.push_back(typed ? want : predicted);
    gap = back_to_back ? 0 : idle_len();
    if (gap > 0) begin
      smp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every booked result has come out.
  task automatic wait_results_drained();
    smp_ch.valid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk);
  endtask

  // Write all three gains back to back, optionally poking the spare index first.
  // Call only with the block idle.
  task automatic write_gains(input logic [VW-1:0] gp, input logic [VW-1:0] gi,
                             input logic [VW-1:0] gd, input bit poke);
    logic [CFG_IDX_W-1:0] idx;
    logic [VW-1:0] val;
    for (int k = (poke ? 0 : 1); k < 4; k++) begin
      case (k)
        0: begin
          idx = REG_SPARE;
          val = $urandom;
        end
        1: begin
          idx = REG_GAIN_PROP;
          val = gp;
        end
        2: begin
          idx = REG_GAIN_INTEG;
          val = gi;
        end
        default: begin
          idx = REG_GAIN_DERIV;
          val = gd;
        end
      endcase
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= val;
      do @(posedge clk); while (!cfg_ch.ready);
      case (idx)
        REG_GAIN_PROP:  gain_p = val;
        REG_GAIN_INTEG: gain_i = val;
        REG_GAIN_DERIV: gain_d = val;
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Result sink: random ready, stretches of steady ready, and a long hold-off
  // whenever the sequencer asks for one.
  initial begin : result_sink
    int gap;
    res_ch.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_requests != holds_done) begin
        res_ch.ready <= 1'b0;
        repeat (RESULT_HOLD) @(posedge clk);
        holds_done++;
      end else if ($urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(20, 120)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
        gap = idle_len();
        if (gap > 0) begin
          res_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Score each result against the oldest booked expectation, field by field.
  always @(posedge clk) begin : score_result
    outcome_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (drive_expected.size() == 0) begin
        flag_mismatch("result with nothing pending", res_ch.drive, '0);
      end else begin
        want = drive_expected.pop_front();
        if (res_ch.drive !== want.drive)
          flag_mismatch("drive", res_ch.drive, want.drive);
        if (res_ch.clipped !== want.clipped)
          flag_mismatch("clipped", res_ch.clipped, want.clipped);
        if (res_ch.zero_interval !== want.zero_interval)
          flag_mismatch("zero_interval", res_ch.zero_interval, want.zero_interval);
      end
    end
  end

  // Watchdog: end the run when no channel has moved for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : sequencer
    // Drive every input to a known value before the first edge.
    rst              = 1'b1;
    smp_ch.valid     = 1'b0;
    smp_ch.measured  = '0;
    smp_ch.setpoint  = '0;
    smp_ch.deadband  = '0;
    smp_ch.timestamp = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;

    // Directed table. Gains are zero out of reset, so the first rows have
    // results that can be written down directly.
    // First sample at time zero: zero interval straight out of reset.
    directed.push_back(checked_row(32'h0, 32'h0, 31'h0, 48'h0, 32'h0, 1'b0, 1'b1));
    // One second later, error 5.0; zero gains give zero drive. Integral is now 5.0.
    directed.push_back(checked_row(32'h0, 32'h0005_0000, 31'h0, 48'h1_0000,
                                   32'h0, 1'b0, 1'b0));
    directed.push_back(gains_row(32'h0001_0000, 32'h0, 32'h0, 1'b0));
    // Unit proportional gain passes the error through.
    directed.push_back(checked_row(32'h0, 32'h0003_0000, 31'h0, 48'h2_0000,
                                   32'h0003_0000, 1'b0, 1'b0));
    // Error 2.0 inside a band of 3.0 is dropped.
    directed.push_back(checked_row(32'h0001_0000, 32'h0003_0000, 31'h0003_0000, 48'h3_0000,
                                   32'h0, 1'b0, 1'b0));
    // Error equal to the band is kept.
    directed.push_back(checked_row(32'h0, 32'h0003_0000, 31'h0003_0000, 48'h4_0000,
                                   32'h0003_0000, 1'b0, 1'b0));
    // Widest positive error: the error saturates silently, the integral clips.
    directed.push_back(checked_row(32'h8000_0000, 32'h7fff_ffff, 31'h0, 48'h5_0000,
                                   32'h7fff_ffff, 1'b1, 1'b0));
    // Widest negative error at the same time stamp.
    directed.push_back(sample_row(32'h7fff_ffff, 32'h8000_0000, 31'h0, 48'h5_0000));
    directed.push_back(gains_row(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1));
    directed.push_back(sample_row(32'h0, 32'h0001_0000, 31'h0, 48'h6_0000));
    // Time runs backward.
    directed.push_back(sample_row(32'hfffd_0000, 32'h0002_0000, 31'h0, 48'h2_0000));
    directed.push_back(sample_row(32'h0, 32'h0, 31'h0, 48'hffff_ffff_ffff));
    // From the last time stamp back to zero: the widest negative interval.
    directed.push_back(sample_row(32'hffff_ffff, 32'h7fff_ffff, 31'h0, 48'h0));
    // Widest band drops a small error.
    directed.push_back(sample_row(32'h0, 32'h0001_0000, 31'h7fff_ffff, 48'h1_0000));
    directed.push_back(gains_row(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0));
    // Saturated error equals the widest band and is kept.
    directed.push_back(sample_row(32'h8000_0000, 32'h0, 31'h7fff_ffff, 48'h2_0000));
    // Most negative error exceeds the widest band.
    directed.push_back(sample_row(32'h0, 32'h8000_0000, 31'h7fff_ffff, 48'h3_0000));
    directed.push_back(gains_row(32'h0, 32'h0, 32'h0001_0000, 1'b0));
    // Smallest step of time: the derivative saturates.
    directed.push_back(sample_row(32'h0, 32'h7fff_ffff, 31'h0, 48'h3_0001));
    directed.push_back(sample_row(32'h0001_0000, 32'h0, 31'h0, 48'h3_0001));
    directed.push_back(sample_row(32'h1234_5678, 32'h1234_5678, 31'h0, 48'h4_0001));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_GAINS) begin
        wait_results_drained();
        write_gains(directed[i].gp, directed[i].gi, directed[i].gd, directed[i].poke);
      end else begin
        offer_sample(directed[i].stim, directed[i].typed, directed[i].want);
      end
    end
    gen_time = time_prev;

    // Random phases, each with its own gains written while the block is idle.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_results_drained();
      write_gains(pick_gain(), pick_gain(), pick_gain(), (phase % 3) == 1);
      back_to_back = (phase % 4) == 2;
      if (phase == 1) begin
        // Starve the result side while samples keep coming, so the block backs up.
        hold_requests++;
        back_to_back = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++)
        offer_sample(make_sample(), 1'b0, '0);
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && drive_expected.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
design/pdt_pkg.sv
design/pdt_ifs.sv
design/pdt_mul.sv
design/pdt_div.sv
design/pdt_dpath.sv
design/pdt_ctrl.sv
design/pid_deadband_timestamped.sv
dv/pid_deadband_timestamped_test.sv
